// ----- src/tga_rle_pixel_decoder_top_defines.svh -----
// Assertion macros for the TGA run-length pixel decoder.
// Included by the top level; expects clk and arst_n in scope.
`ifndef TGA_RLE_PIXEL_DECODER_TOP_DEFINES_SVH
`define TGA_RLE_PIXEL_DECODER_TOP_DEFINES_SVH

// Check prop in the same cycle in which pre holds
`define TRD_ASSERT_NOW(name, pre, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (prop)) \
		else $error(msg);

// Check prop in the cycle after the one in which pre holds
`define TRD_ASSERT_NEXT(name, pre, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (prop)) \
		else $error(msg);

`endif

// ----- src/trd_pkg.sv -----
// Shared types and constants of the TGA run-length pixel decoder.
// No dependencies; imported by the front, queue, back and top level.
package trd_pkg;

	// Result status codes
	localparam logic [1:0] ST_SPAN   = 2'd0;
	localparam logic [1:0] ST_REJECT = 2'd1;
	localparam logic [1:0] ST_ACCEPT = 2'd2;

	// Header checks
	localparam logic [7:0] KIND_RAW  = 8'd2;
	localparam logic [7:0] KIND_RLE  = 8'd10;
	localparam logic [7:0] DEPTH_32  = 8'd32;
	localparam int         FLIP_BIT  = 4;
	localparam int         RUN_BIT   = 7;

	// One decoded result on its way from front to back (row not yet flipped)
	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] word;
		logic [15:0] row;
		logic [15:0] col;
		logic [7:0]  len;
		logic        clip;
		logic [15:0] width;
		logic [15:0] height;
		logic        last;
		logic        flip;
	} trd_entry_t;

endpackage

// ----- src/trd_in_if.sv -----
// Byte stream channel into the TGA decoder: valid/ready plus one file byte.
// No dependencies.
interface trd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       start_of_file;

	modport source (output valid, output data_byte, output start_of_file, input ready);
	modport sink (input valid, input data_byte, input start_of_file, output ready);
endinterface

// ----- src/trd_out_if.sv -----
// Result channel out of the TGA decoder: valid/ready plus one span or header result.
// No dependencies.
interface trd_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] pixel_word;
	logic [15:0] dest_row;
	logic [15:0] dest_col;
	logic [7:0]  span_length;
	logic        run_clipped;
	logic [15:0] image_width;
	logic [15:0] image_height;
	logic        last_span;

	modport source (output valid, output status, output pixel_word, output dest_row,
		output dest_col, output span_length, output run_clipped, output image_width,
		output image_height, output last_span, input ready);
	modport sink (input valid, input status, input pixel_word, input dest_row,
		input dest_col, input span_length, input run_clipped, input image_width,
		input image_height, input last_span, output ready);
endinterface

// ----- src/trd_front.sv -----
// Front of the TGA decoder: header parser, packet and pixel gathering, span positions.
// Depends on trd_pkg; pushes trd_entry_t items into the queue.
module trd_front
	import trd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_ready,
	input  logic [7:0]  data_byte,
	input  logic        start_of_file,
	input  logic        queue_full,
	output logic        push,
	output trd_entry_t  push_entry
);

	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_HEADER = 3'd1;
	localparam logic [2:0] PH_SKIPID = 3'd2;
	localparam logic [2:0] PH_PKTHDR = 3'd3;
	localparam logic [2:0] PH_PIXEL  = 3'd4;
	localparam logic [2:0] PH_DONE   = 3'd5;

	localparam logic [4:0] HB_ID_LEN = 5'd0;
	localparam logic [4:0] HB_CMAP   = 5'd1;
	localparam logic [4:0] HB_KIND   = 5'd2;
	localparam logic [4:0] HB_W_LO   = 5'd12;
	localparam logic [4:0] HB_W_HI   = 5'd13;
	localparam logic [4:0] HB_H_LO   = 5'd14;
	localparam logic [4:0] HB_H_HI   = 5'd15;
	localparam logic [4:0] HB_DEPTH  = 5'd16;
	localparam logic [4:0] HB_DESC   = 5'd17;

	logic [2:0]  phase_q, phase_d, phase_cur;
	logic [4:0]  hdr_cnt_q, hdr_cnt_d, hdr_cnt_cur;
	logic [7:0]  id_left_q, id_left_d;
	logic [7:0]  cmap_q, cmap_d;
	logic [7:0]  kind_q, kind_d;
	logic [7:0]  depth_q, depth_d;
	logic        flip_q, flip_d;
	logic [15:0] width_q, width_d;
	logic [15:0] height_q, height_d;
	logic [15:0] row_q, row_d;
	logic [15:0] col_q, col_d;
	logic        is_run_q, is_run_d;
	logic [7:0]  pkt_left_q, pkt_left_d;
	logic [1:0]  cbi_q, cbi_d;
	logic [23:0] partial_q, partial_d;

	logic        accept;
	logic        enter_data;
	logic        emit;
	logic [7:0]  span_len;
	logic        span_clip;
	logic [16:0] room;
	logic [16:0] next_col;
	logic [15:0] row_inc;

	assign byte_ready = !queue_full;
	assign accept     = byte_valid && byte_ready;

	always_comb begin
		phase_cur   = start_of_file ? PH_HEADER : phase_q;
		hdr_cnt_cur = start_of_file ? 5'd0 : hdr_cnt_q;
		phase_d     = phase_cur;
		hdr_cnt_d   = hdr_cnt_cur;
		id_left_d   = id_left_q;
		cmap_d      = cmap_q;
		kind_d      = kind_q;
		depth_d     = depth_q;
		flip_d      = flip_q;
		width_d     = width_q;
		height_d    = height_q;
		row_d       = row_q;
		col_d       = col_q;
		is_run_d    = is_run_q;
		pkt_left_d  = pkt_left_q;
		cbi_d       = cbi_q;
		partial_d   = partial_q;
		enter_data  = 1'b0;
		emit        = 1'b0;
		span_len    = 8'd1;
		span_clip   = 1'b0;
		room        = {1'b0, width_q} - {1'b0, col_q};
		next_col    = 17'd0;
		row_inc     = row_q + 16'd1;
		push        = 1'b0;
		push_entry  = '0;
		push_entry.width  = width_q;
		push_entry.height = height_q;

		case (phase_cur)
			PH_HEADER: begin
				case (hdr_cnt_cur)
					HB_ID_LEN: id_left_d = data_byte;
					HB_CMAP:   cmap_d    = data_byte;
					HB_KIND:   kind_d    = data_byte;
					HB_W_LO:   width_d   = {width_q[15:8], data_byte};
					HB_W_HI:   width_d   = {data_byte, width_q[7:0]};
					HB_H_LO:   height_d  = {height_q[15:8], data_byte};
					HB_H_HI:   height_d  = {data_byte, height_q[7:0]};
					HB_DEPTH:  depth_d   = data_byte;
					HB_DESC:   flip_d    = data_byte[FLIP_BIT];
					default:   ;
				endcase
				if (hdr_cnt_cur < HB_DESC) begin
					hdr_cnt_d = hdr_cnt_cur + 5'd1;
				end else begin
					hdr_cnt_d = 5'd0;
					push      = 1'b1;
					if (cmap_q != 8'd0 || (kind_q != KIND_RLE && kind_q != KIND_RAW)
						|| depth_q != DEPTH_32) begin
						phase_d           = PH_DONE;
						push_entry.status = ST_REJECT;
					end else if (width_q == 16'd0 || height_q == 16'd0) begin
						phase_d           = PH_DONE;
						push_entry.status = ST_ACCEPT;
						push_entry.last   = 1'b1;
					end else begin
						push_entry.status = ST_ACCEPT;
						if (id_left_q != 8'd0) begin
							phase_d = PH_SKIPID;
						end else begin
							enter_data = 1'b1;
						end
					end
				end
			end
			PH_SKIPID: begin
				id_left_d = id_left_q - 8'd1;
				if (id_left_d == 8'd0) begin
					enter_data = 1'b1;
				end
			end
			PH_PKTHDR: begin
				is_run_d   = data_byte[RUN_BIT];
				pkt_left_d = {1'b0, data_byte[6:0]} + 8'd1;
				cbi_d      = 2'd0;
				partial_d  = 24'd0;
				phase_d    = PH_PIXEL;
			end
			PH_PIXEL: begin
				if (cbi_q != 2'd3) begin
					partial_d = partial_q | ({16'd0, data_byte} << {cbi_q, 3'b000});
					cbi_d     = cbi_q + 2'd1;
				end else begin
					cbi_d     = 2'd0;
					partial_d = 24'd0;
					emit      = 1'b1;
					if (kind_q != KIND_RLE) begin
						span_len = 8'd1;
					end else if (is_run_q) begin
						span_len = pkt_left_q;
						if ({9'd0, pkt_left_q} > room) begin
							span_len  = room[7:0];
							span_clip = 1'b1;
						end
						pkt_left_d = 8'd0;
						phase_d    = PH_PKTHDR;
					end else begin
						pkt_left_d = pkt_left_q - 8'd1;
						if (pkt_left_d == 8'd0) begin
							phase_d = PH_PKTHDR;
						end
					end
				end
			end
			default: ;
		endcase

		// Fresh image body: clear position and packet state and pick the first body phase
		if (enter_data) begin
			row_d      = 16'd0;
			col_d      = 16'd0;
			cbi_d      = 2'd0;
			partial_d  = 24'd0;
			pkt_left_d = 8'd0;
			is_run_d   = 1'b0;
			if (width_q == 16'd0 || height_q == 16'd0) begin
				phase_d = PH_DONE;
			end else if (kind_q == KIND_RLE) begin
				phase_d = PH_PKTHDR;
			end else begin
				phase_d = PH_PIXEL;
			end
		end

		// Place the span and advance the raster position
		if (emit) begin
			push              = 1'b1;
			push_entry.status = ST_SPAN;
			push_entry.word   = {data_byte, partial_q};
			push_entry.row    = row_q;
			push_entry.col    = col_q;
			push_entry.len    = span_len;
			push_entry.clip   = span_clip;
			push_entry.flip   = flip_q;
			next_col          = {1'b0, col_q} + {9'd0, span_len};
			if (next_col >= {1'b0, width_q}) begin
				col_d = 16'd0;
				row_d = row_inc;
				if (row_inc >= height_q) begin
					push_entry.last = 1'b1;
					phase_d         = PH_DONE;
				end
			end else begin
				col_d = next_col[15:0];
			end
		end

		push = push && accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			hdr_cnt_q  <= '0;
			id_left_q  <= '0;
			cmap_q     <= '0;
			kind_q     <= '0;
			depth_q    <= '0;
			flip_q     <= 1'b0;
			width_q    <= '0;
			height_q   <= '0;
			row_q      <= '0;
			col_q      <= '0;
			is_run_q   <= 1'b0;
			pkt_left_q <= '0;
			cbi_q      <= '0;
			partial_q  <= '0;
		end else if (accept) begin
			phase_q    <= phase_d;
			hdr_cnt_q  <= hdr_cnt_d;
			id_left_q  <= id_left_d;
			cmap_q     <= cmap_d;
			kind_q     <= kind_d;
			depth_q    <= depth_d;
			flip_q     <= flip_d;
			width_q    <= width_d;
			height_q   <= height_d;
			row_q      <= row_d;
			col_q      <= col_d;
			is_run_q   <= is_run_d;
			pkt_left_q <= pkt_left_d;
			cbi_q      <= cbi_d;
			partial_q  <= partial_d;
		end
	end

endmodule

// ----- src/trd_queue.sv -----
// Short queue of decoded results between the front and the back of the TGA decoder.
// Depends on trd_pkg for trd_entry_t.
module trd_queue
	import trd_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  trd_entry_t push_entry,
	output logic       full,
	input  logic       pop,
	output logic       not_empty,
	output trd_entry_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	trd_entry_t       slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_FULL);
	assign not_empty = (count_q != '0);
	assign head      = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: ;
			endcase
		end
	end

endmodule

// ----- src/trd_back.sv -----
// Back of the TGA decoder: applies the vertical flip and holds the result register.
// Depends on trd_pkg and trd_out_if.
module trd_back
	import trd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  trd_entry_t head,
	output logic       pop,
	trd_out_if.source  spans
);

	logic        valid_q;
	logic [15:0] dest_row;

	assign pop      = head_valid && (!valid_q || spans.ready);
	assign dest_row = head.flip ? (head.height - 16'd1 - head.row) : head.row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || spans.ready) begin
			valid_q <= head_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			spans.status       <= head.status;
			spans.pixel_word   <= head.word;
			spans.dest_row     <= dest_row;
			spans.dest_col     <= head.col;
			spans.span_length  <= head.len;
			spans.run_clipped  <= head.clip;
			spans.image_width  <= head.width;
			spans.image_height <= head.height;
			spans.last_span    <= head.last;
		end
	end

	assign spans.valid = valid_q;

endmodule

// ----- src/tga_rle_pixel_decoder_top.sv -----
// Usage of the TGA run-length pixel decoder (32-bit true-color, raw or RLE).
// Channels: file_bytes carries one file byte per beat, with start_of_file set on
// header byte 0; spans carries one result per beat: a header verdict (status
// reject or accept, with width and height) or a pixel span (word, row, column,
// length, clip flag, last flag).
// Throughput: one byte per cycle while the queue is not full; every byte costs constant work in the
// front, which is the single stage that sets the rate.
// Path: a byte that completes a result is pushed into the queue at its beat; the
// result then passes from the queue into the output register, from which spans
// presents it until it is taken.
// Reset: the parser goes idle and ignores bytes until one with start_of_file;
// queue and output register are emptied. start_of_file restarts parsing at any time.
// Stall: the queue (QUEUE_DEPTH results) plus the output register absorb a stalled
// receiver; once the queue is full, file_bytes.ready drops until a result leaves.
// Nothing is produced after the last span or after a rejected header until the
// next start_of_file.
`include "tga_rle_pixel_decoder_top_defines.svh"

module tga_rle_pixel_decoder_top
	import trd_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic     clk,
	input  logic     arst_n,
	trd_in_if.sink   file_bytes,
	trd_out_if.source spans
);

	logic       push;
	logic       queue_full;
	logic       pop;
	logic       head_valid;
	trd_entry_t push_entry;
	trd_entry_t head;

	// Parse and place: one byte per beat, at most one result pushed
	trd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_valid    (file_bytes.valid),
		.byte_ready    (file_bytes.ready),
		.data_byte     (file_bytes.data_byte),
		.start_of_file (file_bytes.start_of_file),
		.queue_full    (queue_full),
		.push          (push),
		.push_entry    (push_entry)
	);

	// Decouple the parser from a stalling receiver
	trd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (queue_full),
		.pop        (pop),
		.not_empty  (head_valid),
		.head       (head)
	);

	// Flip rows and hold the result until taken
	trd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.spans      (spans)
	);

	`TRD_ASSERT_NOW(a_no_push_when_full, push, !queue_full, "push into a full queue")
	`TRD_ASSERT_NOW(a_pop_needs_item, pop, head_valid, "pop from an empty queue")
	`TRD_ASSERT_NOW(a_span_nonzero, spans.valid && spans.status == ST_SPAN, spans.span_length != 8'd0, "span of length zero")
	`TRD_ASSERT_NOW(a_span_in_row, spans.valid && spans.status == ST_SPAN, spans.dest_col < spans.image_width, "span column beyond image width")
	`TRD_ASSERT_NEXT(a_hold_on_stall, spans.valid && !spans.ready, spans.valid, "beat dropped while stalled")

endmodule
